/* hdl/imuo_pkg.sv */
// ----------------------------------------------------------------------------
// IMU frame offset and moving average: shared definitions
// Widths, register indexes, history geometry and the reciprocal constant
// used to divide the window sum.
// ----------------------------------------------------------------------------
package imuo_pkg;

  localparam int AvgWindow  = 5;
  localparam int HistDepth  = AvgWindow - 1;
  localparam int NumAxes    = 3;
  localparam int NumOffsets = 6;
  localparam int FrameBytes = 14;

  localparam int ByteW   = 8;
  localparam int WordW   = 16;
  localparam int SampleW = 17;
  localparam int PosW    = 4;
  localparam int CfgIdxW = 3;

  localparam logic [PosW-1:0] PosIdle = PosW'(FrameBytes);
  localparam logic [PosW-1:0] PosLast = PosW'(FrameBytes - 1);

  localparam int SumW       = SampleW + $clog2(AvgWindow);
  localparam int MagW       = SumW - 1;
  localparam int RecipShift = MagW + 4;
  localparam int ProdW      = MagW + RecipShift;
  localparam logic [RecipShift-1:0] Recip =
    RecipShift'((2 ** RecipShift + AvgWindow - 1) / AvgWindow);

  localparam int PtrW     = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int MemDepth = NumAxes * HistDepth;
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  localparam int OutW   = 9 * SampleW + WordW;
  localparam int TdataW = ((OutW + 7) / 8) * 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACCEL_X_OFFSET = 3'd0,
    REG_ACCEL_Y_OFFSET = 3'd1,
    REG_ACCEL_Z_OFFSET = 3'd2,
    REG_GYRO_X_OFFSET  = 3'd3,
    REG_GYRO_Y_OFFSET  = 3'd4,
    REG_GYRO_Z_OFFSET  = 3'd5
  } reg_index_t;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [WordW-1:0]   word_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] axis;
  } acc_ev_t;

  typedef struct packed {
    sample_t [NumAxes-1:0] accel;
    word_t                 temp;
    sample_t [NumAxes-1:0] gyro;
  } frame_t;

  typedef struct packed {
    logic                       valid;
    logic [NumAxes-1:0][SumW-1:0] sum;
  } sums_t;

  typedef struct packed {
    logic                  valid;
    sample_t [NumAxes-1:0] avg;
  } avg_t;

  function automatic logic signed [SumW-1:0] sext_sum(input sample_t s);
    return {{(SumW - SampleW){s[SampleW-1]}}, s};
  endfunction

  function automatic logic [AddrW-1:0] hist_addr(input logic [1:0] axis,
                                                 input logic [PtrW-1:0] ptr);
    return AddrW'(int'(axis) * HistDepth + int'(ptr));
  endfunction

endpackage

/* hdl/imuo_assemble.sv */
// ----------------------------------------------------------------------------
// IMU frame assembler
// Tracks the byte position, joins byte pairs into words, subtracts the axis
// offsets and stages the words until the frame completes.
// ----------------------------------------------------------------------------
module imuo_assemble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [imuo_pkg::ByteW-1:0]    data_byte,
  input  logic                          frame_start,
  input  logic                          cfg_we,
  input  logic [imuo_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [imuo_pkg::WordW-1:0]    cfg_data,
  output logic                          at_last,
  output imuo_pkg::acc_ev_t             acc_ev,
  output logic                          done,
  output imuo_pkg::frame_t              frame
);

  typedef enum logic [2:0] {
    SLOT_ACCEL_X = 3'd0,
    SLOT_ACCEL_Y = 3'd1,
    SLOT_ACCEL_Z = 3'd2,
    SLOT_TEMP    = 3'd3,
    SLOT_GYRO_X  = 3'd4,
    SLOT_GYRO_Y  = 3'd5,
    SLOT_GYRO_Z  = 3'd6
  } slot_t;

  logic [imuo_pkg::PosW-1:0]  pos;
  logic [imuo_pkg::PosW-1:0]  pos_eff;
  logic [imuo_pkg::ByteW-1:0] hold;
  imuo_pkg::word_t            offs [imuo_pkg::NumOffsets];
  imuo_pkg::word_t            word;
  imuo_pkg::word_t            off_sel;
  imuo_pkg::sample_t          corr;
  imuo_pkg::sample_t          stg_acc [imuo_pkg::NumAxes];
  imuo_pkg::word_t            stg_temp;
  imuo_pkg::sample_t          stg_gyro [2];
  logic [2:0]                 slot;
  logic                       in_frame;
  logic                       fire_word;

  assign pos_eff   = frame_start ? '0 : pos;
  assign in_frame  = pos_eff < imuo_pkg::PosIdle;
  assign slot      = pos_eff[3:1];
  assign word      = {hold, data_byte};
  assign fire_word = in_fire && in_frame && pos_eff[0];
  assign done      = fire_word && (pos_eff == imuo_pkg::PosLast);
  assign at_last   = pos == imuo_pkg::PosLast;

  assign acc_ev.valid = fire_word && (slot < 3'(imuo_pkg::NumAxes));
  assign acc_ev.axis  = slot[1:0];

  always_comb begin
    case (slot_t'(slot))
      SLOT_ACCEL_X: off_sel = offs[imuo_pkg::REG_ACCEL_X_OFFSET];
      SLOT_ACCEL_Y: off_sel = offs[imuo_pkg::REG_ACCEL_Y_OFFSET];
      SLOT_ACCEL_Z: off_sel = offs[imuo_pkg::REG_ACCEL_Z_OFFSET];
      SLOT_GYRO_X:  off_sel = offs[imuo_pkg::REG_GYRO_X_OFFSET];
      SLOT_GYRO_Y:  off_sel = offs[imuo_pkg::REG_GYRO_Y_OFFSET];
      SLOT_GYRO_Z:  off_sel = offs[imuo_pkg::REG_GYRO_Z_OFFSET];
      default:      off_sel = '0;
    endcase
  end

  assign corr = $signed({word[imuo_pkg::WordW-1], word}) -
                $signed({off_sel[imuo_pkg::WordW-1], off_sel});

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= imuo_pkg::PosIdle;
      hold <= '0;
      for (int i = 0; i < imuo_pkg::NumOffsets; i++) begin
        offs[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (imuo_pkg::reg_index_t'(cfg_index))
          imuo_pkg::REG_ACCEL_X_OFFSET: offs[imuo_pkg::REG_ACCEL_X_OFFSET] <= cfg_data;
          imuo_pkg::REG_ACCEL_Y_OFFSET: offs[imuo_pkg::REG_ACCEL_Y_OFFSET] <= cfg_data;
          imuo_pkg::REG_ACCEL_Z_OFFSET: offs[imuo_pkg::REG_ACCEL_Z_OFFSET] <= cfg_data;
          imuo_pkg::REG_GYRO_X_OFFSET:  offs[imuo_pkg::REG_GYRO_X_OFFSET]  <= cfg_data;
          imuo_pkg::REG_GYRO_Y_OFFSET:  offs[imuo_pkg::REG_GYRO_Y_OFFSET]  <= cfg_data;
          imuo_pkg::REG_GYRO_Z_OFFSET:  offs[imuo_pkg::REG_GYRO_Z_OFFSET]  <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && in_frame) begin
        if (!pos_eff[0]) begin
          hold <= data_byte;
        end
        pos <= done ? imuo_pkg::PosIdle : pos_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_word && !done) begin
      case (slot_t'(slot))
        SLOT_ACCEL_X: stg_acc[0] <= corr;
        SLOT_ACCEL_Y: stg_acc[1] <= corr;
        SLOT_ACCEL_Z: stg_acc[2] <= corr;
        SLOT_TEMP:    stg_temp   <= word;
        SLOT_GYRO_X:  stg_gyro[0] <= corr;
        SLOT_GYRO_Y:  stg_gyro[1] <= corr;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < imuo_pkg::NumAxes; i++) begin
      frame.accel[i] = stg_acc[i];
    end
    frame.temp    = stg_temp;
    frame.gyro[0] = stg_gyro[0];
    frame.gyro[1] = stg_gyro[1];
    frame.gyro[2] = corr;
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> pos == imuo_pkg::PosIdle)
    else $error("position did not return to idle after the last byte");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && frame_start) |=> pos == imuo_pkg::PosW'(1))
    else $error("frame start did not restart the byte position");

endmodule

/* hdl/imuo_hist.sv */
// ----------------------------------------------------------------------------
// IMU accelerometer history
// Ring memory of previous corrected samples per axis with running sums.
// The oldest entry is read when an axis word arrives and replaced starting
// when the frame completes; the three write-backs share one port in turn.
// ----------------------------------------------------------------------------
module imuo_hist (
  input  logic                                      clk,
  input  logic                                      rst,
  input  imuo_pkg::acc_ev_t                         acc_ev,
  input  logic                                      done,
  input  imuo_pkg::sample_t [imuo_pkg::NumAxes-1:0] acc,
  output imuo_pkg::sums_t                           sums
);

  imuo_pkg::sample_t             mem [imuo_pkg::MemDepth];
  logic [imuo_pkg::MemDepth-1:0] vld;
  logic [imuo_pkg::PtrW-1:0]     ptr;
  logic [imuo_pkg::PtrW-1:0]     wb_ptr;
  logic                          wb_act;
  logic [1:0]                    wb_axis;
  logic                          rd_pend;
  logic [1:0]                    rd_axis;
  imuo_pkg::sample_t             rd_q;
  logic                          rd_v;
  imuo_pkg::sample_t             old [imuo_pkg::NumAxes];
  logic signed [imuo_pkg::SumW-1:0] hsum [imuo_pkg::NumAxes];
  logic                          wr_en;
  logic [imuo_pkg::AddrW-1:0]    wr_addr;
  logic [imuo_pkg::AddrW-1:0]    rd_addr;
  imuo_pkg::sample_t             wr_data;

  assign rd_addr = imuo_pkg::hist_addr(acc_ev.axis, ptr);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = imuo_pkg::hist_addr(wb_axis, wb_ptr);
    wr_data = acc[wb_axis];
    if (done) begin
      wr_en   = 1'b1;
      wr_addr = imuo_pkg::hist_addr(2'd0, ptr);
      wr_data = acc[0];
    end else if (wb_act) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (acc_ev.valid) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      old[rd_axis] <= rd_v ? rd_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      ptr        <= '0;
      wb_ptr     <= '0;
      wb_act     <= 1'b0;
      wb_axis    <= '0;
      rd_pend    <= 1'b0;
      rd_axis    <= '0;
      rd_v       <= 1'b0;
      sums.valid <= 1'b0;
      for (int a = 0; a < imuo_pkg::NumAxes; a++) begin
        hsum[a] <= '0;
      end
    end else begin
      rd_pend    <= acc_ev.valid;
      sums.valid <= done;
      if (acc_ev.valid) begin
        rd_axis <= acc_ev.axis;
        rd_v    <= vld[rd_addr];
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (done) begin
        for (int a = 0; a < imuo_pkg::NumAxes; a++) begin
          sums.sum[a] <= hsum[a] + imuo_pkg::sext_sum(acc[a]);
          hsum[a] <= hsum[a] + imuo_pkg::sext_sum(acc[a]) - imuo_pkg::sext_sum(old[a]);
        end
        wb_act  <= 1'b1;
        wb_axis <= 2'd1;
        wb_ptr  <= ptr;
        ptr     <= (ptr == imuo_pkg::PtrW'(imuo_pkg::HistDepth - 1)) ? '0 : ptr + 1'b1;
      end else if (wb_act) begin
        wb_axis <= wb_axis + 2'd1;
        wb_act  <= wb_axis != 2'(imuo_pkg::NumAxes - 1);
      end
    end
  end

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && acc_ev.valid && (wr_addr == rd_addr)))
    else $error("history entry read and written in the same cycle");

  a_commit_after_wb: assert property (@(posedge clk) disable iff (rst)
    done |-> !wb_act)
    else $error("frame completed while history write-back still running");

endmodule

/* hdl/imuo_avg.sv */
// ----------------------------------------------------------------------------
// IMU window mean
// Divides each window sum by the window length with a reciprocal multiply,
// truncating toward zero. Two register stages.
// ----------------------------------------------------------------------------
module imuo_avg (
  input  logic            clk,
  input  logic            rst,
  input  imuo_pkg::sums_t sums,
  output imuo_pkg::avg_t  avg
);

  logic [imuo_pkg::NumAxes-1:0]                     neg;
  logic [imuo_pkg::NumAxes-1:0][imuo_pkg::ProdW-1:0] prod;
  logic                                             p_valid;
  logic [imuo_pkg::NumAxes-1:0][imuo_pkg::MagW-1:0] mag;
  imuo_pkg::sample_t [imuo_pkg::NumAxes-1:0]        quo;

  always_comb begin
    for (int a = 0; a < imuo_pkg::NumAxes; a++) begin
      mag[a] = sums.sum[a][imuo_pkg::SumW-1] ?
               imuo_pkg::MagW'(-sums.sum[a]) : imuo_pkg::MagW'(sums.sum[a]);
      quo[a] = prod[a][imuo_pkg::RecipShift +: imuo_pkg::SampleW];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < imuo_pkg::NumAxes; a++) begin
      neg[a]  <= sums.sum[a][imuo_pkg::SumW-1];
      prod[a] <= imuo_pkg::ProdW'(mag[a]) * imuo_pkg::ProdW'(imuo_pkg::Recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      avg.valid <= 1'b0;
    end else begin
      p_valid   <= sums.valid;
      avg.valid <= p_valid;
      for (int a = 0; a < imuo_pkg::NumAxes; a++) begin
        avg.avg[a] <= neg[a] ? (~quo[a] + 1'b1) : quo[a];
      end
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    sums.valid |=> ##1 avg.valid)
    else $error("window mean did not follow its sum after two cycles");

endmodule

/* hdl/imu_frame_offset_moving_average.sv */
// ----------------------------------------------------------------------------
// IMU frame offset and moving average
// Assembles a 14-byte sensor frame, subtracts the offsets and gives a
// windowed mean per accelerometer axis.
//
//   channel  dir  beat
//   s_*      in   one frame byte; tuser is the frame start flag
//   m_*      out  one corrected frame with accelerometer means
//   cfg_*    in   offset register write, index 0..5
//
// One byte is taken per cycle unless held as below. A result passes the window
// sum, multiply, sign and output register stages after the last byte of a frame.
// The history memory is written back starting with the last byte of a frame,
// one axis per cycle on its single write port.
// The last byte of a frame waits while a previous result is still stalled.
// Reset clears position, offsets, history and running sums.
// ----------------------------------------------------------------------------
module imu_frame_offset_moving_average (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [imuo_pkg::ByteW-1:0]          s_tdata,   // data_byte[7:0]
  input  logic                                s_tuser,   // frame_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // accel_x, accel_y, accel_z, temp_raw, gyro_x, gyro_y, gyro_z,
  // avg_accel_x, avg_accel_y, avg_accel_z, zero fill
  output logic [imuo_pkg::TdataW-1:0]         m_tdata,
  input  logic                                cfg_we,
  input  logic [imuo_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [imuo_pkg::WordW-1:0]          cfg_data
);

  logic              in_fire;
  logic              at_last;
  logic              done;
  imuo_pkg::acc_ev_t acc_ev;
  imuo_pkg::frame_t  frame;
  imuo_pkg::frame_t  frm_q;
  imuo_pkg::sums_t   sums;
  imuo_pkg::avg_t    avg;

  assign s_tready = !(at_last && m_tvalid && !m_tready);
  assign in_fire  = s_tvalid && s_tready;

  imuo_assemble u_assemble (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .data_byte   (s_tdata),
    .frame_start (s_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .at_last     (at_last),
    .acc_ev      (acc_ev),
    .done        (done),
    .frame       (frame)
  );

  imuo_hist u_hist (
    .clk    (clk),
    .rst    (rst),
    .acc_ev (acc_ev),
    .done   (done),
    .acc    (frame.accel),
    .sums   (sums)
  );

  imuo_avg u_avg (
    .clk  (clk),
    .rst  (rst),
    .sums (sums),
    .avg  (avg)
  );

  always_ff @(posedge clk) begin
    if (done) begin
      frm_q <= frame;
    end
    if (avg.valid) begin
      m_tdata <= {{(imuo_pkg::TdataW - imuo_pkg::OutW){1'b0}},
                  avg.avg[2], avg.avg[1], avg.avg[0],
                  frm_q.gyro[2], frm_q.gyro[1], frm_q.gyro[0],
                  frm_q.temp,
                  frm_q.accel[2], frm_q.accel[1], frm_q.accel[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (avg.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(avg.valid && m_tvalid))
    else $error("new result arrived while the output register was full");

endmodule

/* bench/imu_frame_offset_moving_average_tb.sv */
// ----------------------------------------------------------------------------
// IMU frame offset and moving average testbench
// Streams 14-byte sensor frames into the block and compares every output beat
// with frames predicted from the accepted bytes and the offset registers.
// The stimulus covers extreme words and offsets, dropped and restarted frames,
// stray bytes, and random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module imu_frame_offset_moving_average_tb;

  localparam int NumFields   = 10;
  localparam int TempField   = 3;
  localparam int DrainCycles = 8;
  localparam int PhaseBytes  = 350;
  localparam int HoldCycles  = 400;

  localparam logic [imuo_pkg::CfgIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [imuo_pkg::CfgIdxW-1:0] RegSpareHigh = 3'd7;

  typedef logic [NumFields-1:0][imuo_pkg::SampleW-1:0] frame_fields_t;

  class imu_frame_checker;
    logic [imuo_pkg::WordW-1:0] offset_reg[imuo_pkg::NumOffsets];
    logic [imuo_pkg::PosW-1:0]  byte_pos;
    logic [imuo_pkg::ByteW-1:0] high_byte;
    logic [imuo_pkg::WordW-1:0] words[imuo_pkg::NumOffsets];
    int               accel_hist[imuo_pkg::NumAxes][imuo_pkg::HistDepth];
    frame_fields_t    pending_frames[$];
    int               errors;

    function new();
      foreach (offset_reg[i]) offset_reg[i] = '0;
      foreach (words[i]) words[i] = '0;
      foreach (accel_hist[a, k]) accel_hist[a][k] = 0;
      byte_pos  = imuo_pkg::PosIdle;
      high_byte = '0;
      errors    = 0;
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    function void note_config(logic [imuo_pkg::CfgIdxW-1:0] idx,
                              logic [imuo_pkg::WordW-1:0] val);
      if (idx < imuo_pkg::NumOffsets) offset_reg[idx] = val;
    endfunction

    function void note_byte(logic [imuo_pkg::ByteW-1:0] b, logic start);
      logic [imuo_pkg::WordW-1:0] last_word;
      int            corr[7];
      int            sum;
      frame_fields_t want;
      if (start) byte_pos = '0;
      if (byte_pos >= imuo_pkg::FrameBytes) return;
      if (!byte_pos[0]) begin
        high_byte = b;
        byte_pos++;
        return;
      end
      if (byte_pos < imuo_pkg::PosLast) begin
        words[byte_pos >> 1] = {high_byte, b};
        byte_pos++;
        return;
      end
      byte_pos  = imuo_pkg::PosIdle;
      last_word = {high_byte, b};
      // Word order: accel x, y, z, temperature, gyro x, y, z.
      for (int a = 0; a < imuo_pkg::NumAxes; a++)
        corr[a] = int'($signed(words[a])) - int'($signed(offset_reg[a]));
      corr[3] = int'($signed(words[3]));
      corr[4] = int'($signed(words[4])) - int'($signed(offset_reg[3]));
      corr[5] = int'($signed(words[5])) - int'($signed(offset_reg[4]));
      corr[6] = int'($signed(last_word)) - int'($signed(offset_reg[5]));
      for (int i = 0; i < 7; i++) want[i] = imuo_pkg::SampleW'(corr[i]);
      want[TempField] = {1'b0, words[3]};
      for (int a = 0; a < imuo_pkg::NumAxes; a++) begin
        sum = corr[a];
        for (int k = 0; k < imuo_pkg::HistDepth; k++) sum += accel_hist[a][k];
        for (int k = imuo_pkg::HistDepth - 1; k > 0; k--)
          accel_hist[a][k] = accel_hist[a][k-1];
        accel_hist[a][0] = corr[a];
        want[7+a] = imuo_pkg::SampleW'(sum / imuo_pkg::AvgWindow);
      end
      pending_frames.push_back(want);
    endfunction

    function string field_name(int i);
      case (i)
        0: return "accel_x";
        1: return "accel_y";
        2: return "accel_z";
        3: return "temp_raw";
        4: return "gyro_x";
        5: return "gyro_y";
        6: return "gyro_z";
        7: return "avg_accel_x";
        8: return "avg_accel_y";
        default: return "avg_accel_z";
      endcase
    endfunction

    function void check_frame(logic [imuo_pkg::TdataW-1:0] beat);
      frame_fields_t got;
      frame_fields_t want;
      int            lsb;
      lsb = 0;
      for (int i = 0; i < NumFields; i++) begin
        got[i] = imuo_pkg::SampleW'(beat >> lsb);
        if (i == TempField) begin
          got[i][imuo_pkg::SampleW-1] = 1'b0;
          lsb += imuo_pkg::WordW;
        end else begin
          lsb += imuo_pkg::SampleW;
        end
      end
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing expected, expected none actual %h",
                 $time, beat);
        return;
      end
      want = pending_frames.pop_front();
      for (int i = 0; i < NumFields; i++) begin
        if (got[i] !== want[i]) begin
          errors++;
          $display("%0t: %s mismatch, expected %h actual %h",
                   $time, field_name(i), want[i], got[i]);
        end
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [imuo_pkg::ByteW-1:0]         s_tdata;
  logic                               s_tuser;
  logic                               m_tvalid;
  logic                               m_tready;
  logic [imuo_pkg::TdataW-1:0]        m_tdata;
  logic                               cfg_we;
  logic [imuo_pkg::CfgIdxW-1:0]       cfg_index;
  logic [imuo_pkg::WordW-1:0]         cfg_data;

  imu_frame_checker sb = new();
  int src_idle_pct   = 36;
  int sink_stall_pct = 36;
  int hold_left      = 0;

  imu_frame_offset_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_frame(m_tdata);
      if (cfg_we) sb.note_config(cfg_index, cfg_data);
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic logic [imuo_pkg::WordW-1:0] random_word();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return imuo_pkg::WordW'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [imuo_pkg::ByteW-1:0] b, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= imuo_pkg::ByteW'($urandom);
      s_tuser  <= 1'($urandom);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_frame(input logic [imuo_pkg::WordW-1:0] w[7], input int cut);
    for (int k = 0; k < cut; k++)
      send_byte(k[0] ? w[k>>1][7:0] : w[k>>1][15:8], k == 0);
  endtask

  task automatic send_random_frame(output int sent);
    logic [imuo_pkg::WordW-1:0] w[7];
    foreach (w[i]) w[i] = random_word();
    sent = ($urandom_range(99) < 8) ? $urandom_range(imuo_pkg::FrameBytes - 1, 1)
                                    : imuo_pkg::FrameBytes;
    send_frame(w, sent);
    if ($urandom_range(99) < 5) send_byte(imuo_pkg::ByteW'($urandom), 1'b0);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [imuo_pkg::CfgIdxW-1:0] idx,
                           input logic [imuo_pkg::WordW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_bytes(input int quota);
    int count;
    int sent;
    count = 0;
    while (count < quota) begin
      send_random_frame(sent);
      count += sent;
    end
    // Close the phase on a whole frame.
    send_random_frame(sent);
    while (sent != imuo_pkg::FrameBytes) send_random_frame(sent);
  endtask

  initial begin
    logic [imuo_pkg::WordW-1:0] edge_words[7];
    logic [imuo_pkg::WordW-1:0] val;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = imuo_pkg::REG_ACCEL_X_OFFSET;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset offsets: a stray byte while idle, a frame cut short by a new start,
    // a frame of extreme words, then a byte past the end of the frame.
    edge_words = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001};
    send_byte(8'hA5, 1'b0);
    send_frame(edge_words, 5);
    send_frame(edge_words, imuo_pkg::FrameBytes);
    send_byte(8'h5A, 1'b0);
    wait_quiet();

    for (int phase = 1; phase <= 5; phase++) begin
      for (int r = 0; r < imuo_pkg::NumOffsets; r++) begin
        case (phase)
          1: val = 16'h7FFF;
          2: val = 16'h8000;
          4: val = r[0] ? 16'h7FFF : 16'h8000;
          5: val = 16'h0000;
          default: val = imuo_pkg::WordW'($urandom);
        endcase
        write_reg(imuo_pkg::CfgIdxW'(r), val);
      end
      if (phase == 1 || phase == 3) begin
        write_reg(RegSpareLow, imuo_pkg::WordW'($urandom));
        write_reg(RegSpareHigh, 16'hFFFF);
      end
      src_idle_pct   = (phase == 4) ? 0 : 36;
      sink_stall_pct = (phase == 4) ? 0 : 36;
      if (phase == 3) hold_left = HoldCycles;
      run_bytes(PhaseBytes);
      wait_quiet();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/imuo_pkg.sv
hdl/imuo_assemble.sv
hdl/imuo_hist.sv
hdl/imuo_avg.sv
hdl/imu_frame_offset_moving_average.sv
bench/imu_frame_offset_moving_average_tb.sv
